// ===== rtl/vsmp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the trilinear voxel sampler.
// No dependencies.
package vsmp_pkg;

  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int GRID_Z = 64;

  localparam int STORE_AW    = 18;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int IDX_W       = 8;    // holds a corner index up to 255
  localparam int CRD_W       = 24;   // clamped Q8.16 cell coordinate
  localparam int FRAC_W      = 16;

  localparam logic [CRD_W-1:0] TOP_X = CRD_W'((GRID_X - 1) << FRAC_W);
  localparam logic [CRD_W-1:0] TOP_Y = CRD_W'((GRID_Y - 1) << FRAC_W);
  localparam logic [CRD_W-1:0] TOP_Z = CRD_W'((GRID_Z - 1) << FRAC_W);

  localparam logic [47:0] HALF = 48'd32768;
  localparam logic [16:0] ONE  = 17'd65536;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_SCALE_X  = 3'd3,
    REG_SCALE_Y  = 3'd4,
    REG_SCALE_Z  = 3'd5
  } reg_idx_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

endpackage

// ===== rtl/vsmp_ram.sv =====
`timescale 1ns / 1ps
// Single-write, single-read voxel byte memory with registered read data.
// Depends on vsmp_pkg for the store depth.
module vsmp_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [vsmp_pkg::STORE_AW-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic                          re,
  input  logic [vsmp_pkg::STORE_AW-1:0] raddr,
  output logic [7:0]                    rdata
);

  logic [7:0] mem [vsmp_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vsmp_coord.sv =====
`timescale 1ns / 1ps
// Three-stage cell coordinate pipe for one axis: subtract origin, multiply by
// scale, drop half a cell and clamp to the grid. Depends on vsmp_pkg.
module vsmp_coord (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [31:0]                   point,
  input  logic [31:0]                   origin,
  input  logic [31:0]                   scale,
  input  logic [vsmp_pkg::CRD_W-1:0]    top,
  output logic [vsmp_pkg::CRD_W-1:0]    coord
);

  logic [32:0] diff_r;
  logic [63:0] prod_r;
  logic        neg_r;
  logic [vsmp_pkg::CRD_W-1:0] coord_r;
  logic [vsmp_pkg::CRD_W-1:0] coord_nxt;
  logic [47:0] t;
  logic [47:0] tm;

  always_comb begin
    t  = prod_r[63:16];
    tm = t - vsmp_pkg::HALF;
    if (neg_r || t < vsmp_pkg::HALF) begin
      coord_nxt = '0;
    end else if (tm > 48'(top)) begin
      coord_nxt = top;
    end else begin
      coord_nxt = tm[vsmp_pkg::CRD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r  <= {point[31], point} - {origin[31], origin};
      neg_r   <= diff_r[32];
      prod_r  <= 64'(diff_r[31:0]) * 64'(scale);
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

// ===== rtl/trilinear_voxel_sampler.sv =====
`timescale 1ns / 1ps
// Trilinear voxel sampler: voxel byte store plus a query pipeline.
// Depends on vsmp_pkg, vsmp_coord and vsmp_ram.
//
// Input beats on in_*: in_tuser is the kind (0 load, 1 query). A load writes
// voxel_value at voxel_addr and returns nothing. A query maps point_x/y/z to
// cell coordinates, reads the eight neighbor voxels and returns one beat on
// out_* holding the interpolated byte in unsigned Q8.16.
// Configuration: cfg_index selects origin_x/y/z (0..2) or scale_x/y/z (3..5),
// cfg_data carries the value; cfg_ready is always high. Write only when idle.
// Query path: coordinate pipe, addresses, ram read, z, y and x blend, output.
// Throughput: one beat per cycle unless stalled; loads and queries mix freely.
// The voxel memory is kept in eight copies, one per corner, so all eight
// reads happen in the same cycle; every load writes all copies.
// The whole pipe advances together: when out_tvalid is high and out_tready
// is low, in_tready drops and every stage holds; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears the stage valid bits and restores the
// registers to origin 0, scale 1.0. Voxel contents are undefined until loaded.
module trilinear_voxel_sampler (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // [17:0] voxel_addr, [25:18] voxel_value, [57:26] point_x,
  // [89:58] point_y, [121:90] point_z, [127:122] zero
  input  logic [127:0]  in_tdata,
  // [0] kind
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // [23:0] density_value
  output logic [23:0]   out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int AW = vsmp_pkg::STORE_AW;
  localparam int IW = vsmp_pkg::IDX_W;
  localparam int FW = vsmp_pkg::FRAC_W;

  logic [31:0] org_x_r, org_y_r, org_z_r, scl_x_r, scl_y_r, scl_z_r;
  logic        adv;

  // stage valid/kind, s1..s3 alongside coordinate pipe, s4 addresses,
  // s5 ram data, s6 z blend, s7 y blend
  logic [7:1]  vld_r;
  logic [7:1]  qry_r;
  logic [AW-1:0] la_r [4:1];
  logic [7:0]    lv_r [4:1];

  logic [vsmp_pkg::CRD_W-1:0] cx, cy, cz;

  logic [AW-1:0]  ra_r  [8];
  logic [AW-1:0]  ra_nxt[8];
  logic [FW-1:0]  fx_r [7:4];
  logic [FW-1:0]  fy_r [6:4];
  logic [FW-1:0]  fz_r [5:4];
  logic [7:0]     rd   [8];
  logic [23:0]    zb_r [4];
  logic [23:0]    zb_nxt[4];
  logic [39:0]    yb_r [2];
  logic [39:0]    yb_nxt[2];
  logic [55:0]    xb;
  logic [55:0]    xr;
  logic           out_vld_r;
  logic [23:0]    out_dat_r;

  logic [IW-1:0]  xi[2], yi[2], zi[2];
  logic [31:0]    lin[8];

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      scl_x_r <= 32'd65536;
      scl_y_r <= 32'd65536;
      scl_z_r <= 32'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vsmp_pkg::REG_ORIGIN_X: org_x_r <= cfg_data;
        vsmp_pkg::REG_ORIGIN_Y: org_y_r <= cfg_data;
        vsmp_pkg::REG_ORIGIN_Z: org_z_r <= cfg_data;
        vsmp_pkg::REG_SCALE_X:  scl_x_r <= cfg_data;
        vsmp_pkg::REG_SCALE_Y:  scl_y_r <= cfg_data;
        vsmp_pkg::REG_SCALE_Z:  scl_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vsmp_coord u_cx (.clk(clk), .adv(adv), .point(in_tdata[57:26]), .origin(org_x_r),
                   .scale(scl_x_r), .top(vsmp_pkg::TOP_X), .coord(cx));
  vsmp_coord u_cy (.clk(clk), .adv(adv), .point(in_tdata[89:58]), .origin(org_y_r),
                   .scale(scl_y_r), .top(vsmp_pkg::TOP_Y), .coord(cy));
  vsmp_coord u_cz (.clk(clk), .adv(adv), .point(in_tdata[121:90]), .origin(org_z_r),
                   .scale(scl_z_r), .top(vsmp_pkg::TOP_Z), .coord(cz));

  // corner indices and linear addresses, upper corner held at the grid edge
  always_comb begin
    xi[0] = cx[FW +: IW];
    yi[0] = cy[FW +: IW];
    zi[0] = cz[FW +: IW];
    xi[1] = (9'(xi[0]) + 9'd1 < 9'(vsmp_pkg::GRID_X)) ? xi[0] + IW'(1) : xi[0];
    yi[1] = (9'(yi[0]) + 9'd1 < 9'(vsmp_pkg::GRID_Y)) ? yi[0] + IW'(1) : yi[0];
    zi[1] = (9'(zi[0]) + 9'd1 < 9'(vsmp_pkg::GRID_Z)) ? zi[0] + IW'(1) : zi[0];
    for (int k = 0; k < 8; k++) begin
      lin[k] = 32'(xi[k[2]]) + 32'(vsmp_pkg::GRID_X) *
               (32'(yi[k[1]]) + 32'(vsmp_pkg::GRID_Y) * 32'(zi[k[0]]));
      ra_nxt[k] = lin[k][AW-1:0];
    end
  end

  // corner k = {x, y, z} select bits
  for (genvar k = 0; k < 8; k++) begin : g_ram
    vsmp_ram u_ram (
      .clk   (clk),
      .we    (adv && vld_r[4] && !qry_r[4]),
      .waddr (la_r[4]),
      .wdata (lv_r[4]),
      .re    (adv),
      .raddr (ra_r[k]),
      .rdata (rd[k])
    );
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      zb_nxt[j] = 24'(rd[2*j]) * 24'(vsmp_pkg::ONE - 17'(fz_r[5]))
                + 24'(rd[2*j+1]) * 24'(fz_r[5]);
    end
    for (int j = 0; j < 2; j++) begin
      yb_nxt[j] = 40'(zb_r[2*j]) * 40'(vsmp_pkg::ONE - 17'(fy_r[6]))
                + 40'(zb_r[2*j+1]) * 40'(fy_r[6]);
    end
    xb = 56'(yb_r[0]) * 56'(vsmp_pkg::ONE - 17'(fx_r[7]))
       + 56'(yb_r[1]) * 56'(fx_r[7]);
    xr = xb + 56'h8000_0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[6:1], in_tvalid};
      out_vld_r <= vld_r[7] && qry_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qry_r   <= {qry_r[6:1], in_tuser == vsmp_pkg::KIND_QUERY};
      la_r[1] <= in_tdata[17:0];
      lv_r[1] <= in_tdata[25:18];
      for (int s = 2; s <= 4; s++) begin
        la_r[s] <= la_r[s-1];
        lv_r[s] <= lv_r[s-1];
      end
      for (int k = 0; k < 8; k++) begin
        ra_r[k] <= ra_nxt[k];
      end
      fx_r[4] <= cx[FW-1:0];
      fy_r[4] <= cy[FW-1:0];
      fz_r[4] <= cz[FW-1:0];
      fx_r[5] <= fx_r[4];
      fx_r[6] <= fx_r[5];
      fx_r[7] <= fx_r[6];
      fy_r[5] <= fy_r[4];
      fy_r[6] <= fy_r[5];
      fz_r[5] <= fz_r[4];
      zb_r    <= zb_nxt;
      yb_r    <= yb_nxt;
      out_dat_r <= xr[55:32];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(out_dat_r))
    else $error("pipeline moved while stalled");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[7] && !qry_r[7] |=> !out_tvalid)
    else $error("load beat produced a result");

  a_coord_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    cx <= vsmp_pkg::TOP_X && cy <= vsmp_pkg::TOP_Y && cz <= vsmp_pkg::TOP_Z)
    else $error("cell coordinate outside grid");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 24'd16711680)
    else $error("density above full scale");
`endif

endmodule
